// ===== design/vnl_pkg.sv =====
`default_nettype none
package vnl_pkg;
   localparam int COMP_WIDTH_DEFAULT = 16;

   // Port widths of the request and response fields.
   localparam int FIELD_W  = 16;
   localparam int MODE_W   = 2;
   localparam int DIMS_W   = 3;
   localparam int SCALAR_W = 33;

   // Internal widths: a component magnitude never exceeds 16 bits.
   localparam int MAG_W  = 16;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int VAL_W  = SUM_W + 16;
   localparam int ROOT_W = VAL_W / 2;
   localparam int NUM_W  = MAG_W + 23;
   localparam int Q_W    = 15;

   localparam logic [Q_W-1:0]      NORM_ONE   = Q_W'(16384);
   localparam logic [SCALAR_W-1:0] SCALAR_MAX = {SCALAR_W{1'b1}};

   localparam logic [MODE_W-1:0] MODE_NORMALIZE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SUM_SQ    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LENGTH    = 2'd2;
endpackage
`default_nettype wire

// ===== design/vector_normalize_length_unit.sv =====
// Stages: square, sum, 25 square-root stages, divider setup, 15 divider
// stages, output register.
// Throughput: one request per cycle; the pipeline advances whenever the
// output register is empty or being taken, so a stall holds every stage.
// Reset (synchronous, active high) clears all stage valid bits.
`default_nettype none
module vector_normalize_length_unit #(
   parameter int COMP_WIDTH = vnl_pkg::COMP_WIDTH_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire logic [vnl_pkg::MODE_W-1:0]    req_mode,
   input  wire logic [vnl_pkg::DIMS_W-1:0]    req_dims,
   input  wire logic [vnl_pkg::FIELD_W-1:0]   req_comp_x,
   input  wire logic [vnl_pkg::FIELD_W-1:0]   req_comp_y,
   input  wire logic [vnl_pkg::FIELD_W-1:0]   req_comp_z,
   input  wire logic [vnl_pkg::FIELD_W-1:0]   req_comp_w,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_x,
   output      logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_y,
   output      logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_z,
   output      logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_w,
   output      logic [vnl_pkg::SCALAR_W-1:0]  rsp_scalar_result,
   output      logic                          rsp_zero_length
);
   import vnl_pkg::*;

   localparam bit SIGNED_COMP = (COMP_WIDTH <= FIELD_W);
   localparam int SH          = SIGNED_COMP ? (FIELD_W - COMP_WIDTH) : 0;

   logic en;

   // Stage 1: decode and square.
   logic              v1_ff, v1_in;
   logic [MODE_W-1:0] mode1_ff, mode1_in;
   logic [3:0]        neg1_ff, neg1_in;
   logic [MAG_W-1:0]  mag1_ff [4];
   logic [MAG_W-1:0]  mag1_in [4];
   logic [SQ_W-1:0]   sq1_ff [4];
   logic [SQ_W-1:0]   sq1_in [4];

   // Stage 2: sum of squares.
   logic              v2_ff;
   logic [MODE_W-1:0] mode2_ff;
   logic [3:0]        neg2_ff;
   logic [MAG_W-1:0]  mag2_ff [4];
   logic [SUM_W-1:0]  sum2_ff, sum2_in;

   // Square-root stages, one result bit each.
   logic              sv_ff    [ROOT_W];
   logic [MODE_W-1:0] smode_ff [ROOT_W];
   logic [3:0]        sneg_ff  [ROOT_W];
   logic [MAG_W-1:0]  smag_ff  [ROOT_W][4];
   logic [SUM_W-1:0]  ssum_ff  [ROOT_W];
   logic [VAL_W-1:0]  srem_ff  [ROOT_W];
   logic [VAL_W-1:0]  srem_in  [ROOT_W];
   logic [ROOT_W-1:0] sroot_ff [ROOT_W];
   logic [ROOT_W-1:0] sroot_in [ROOT_W];

   // Divider stages: element 0 is the setup, then one quotient bit each.
   localparam int DN = Q_W + 1;
   logic              dv_ff    [DN];
   logic [MODE_W-1:0] dmode_ff [DN];
   logic [3:0]        dneg_ff  [DN];
   logic [SUM_W-1:0]  dsum_ff  [DN];
   logic [ROOT_W-1:0] dlen_ff  [DN];
   logic [NUM_W-1:0]  drem_ff  [DN][4];
   logic [NUM_W-1:0]  drem_in  [DN][4];
   logic [Q_W-1:0]    dq_ff    [DN][4];
   logic [Q_W-1:0]    dq_in    [DN][4];

   // Output register.
   logic                rv_ff;
   logic [FIELD_W-1:0]  rnorm_ff [4];
   logic [FIELD_W-1:0]  rnorm_in [4];
   logic [SCALAR_W-1:0] rscalar_ff, rscalar_in;
   logic                rzero_ff, rzero_in;

   assign en        = !rv_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      logic [FIELD_W-1:0]   field [4];
      logic [FIELD_W-1:0]   shl;
      logic signed [FIELD_W:0] ext;
      logic signed [FIELD_W:0] val;
      logic [FIELD_W:0]     absv;
      logic [DIMS_W-1:0]    dc;
      field[0] = req_comp_x;
      field[1] = req_comp_y;
      field[2] = req_comp_z;
      field[3] = req_comp_w;
      v1_in    = req_valid;
      mode1_in = req_mode;
      priority if (req_dims < DIMS_W'(2)) begin
         dc = DIMS_W'(2);
      end else if (req_dims > DIMS_W'(4)) begin
         dc = DIMS_W'(4);
      end else begin
         dc = req_dims;
      end
      for (int i = 0; i < 4; i++) begin
         shl = field[i] << SH;
         ext = SIGNED_COMP ? $signed({shl[FIELD_W-1], shl}) : $signed({1'b0, field[i]});
         val = ext >>> SH;
         if (DIMS_W'(i) >= dc) begin
            val = '0;
         end
         absv       = val[FIELD_W] ? (FIELD_W+1)'(-val) : (FIELD_W+1)'(val);
         neg1_in[i] = val[FIELD_W];
         mag1_in[i] = absv[MAG_W-1:0];
         sq1_in[i]  = absv[MAG_W-1:0] * absv[MAG_W-1:0];
      end
   end

   assign sum2_in = SUM_W'(sq1_ff[0]) + SUM_W'(sq1_ff[1]) + SUM_W'(sq1_ff[2])
                  + SUM_W'(sq1_ff[3]);

   // Digit-by-digit root of sum * 2^16; each stage tries one bit.
   always_comb begin
      logic [VAL_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [VAL_W+1:0]  trial;
      logic [VAL_W+1:0]  remx;
      for (int j = 0; j < ROOT_W; j++) begin
         if (j == 0) begin
            rem  = {sum2_ff, 16'd0};
            root = '0;
         end else begin
            rem  = srem_ff[j-1];
            root = sroot_ff[j-1];
         end
         trial = {{(VAL_W-ROOT_W){1'b0}}, root, 2'b01} << (2 * (ROOT_W - 1 - j));
         remx  = {2'b00, rem};
         if (remx >= trial) begin
            srem_in[j]  = VAL_W'(remx - trial);
            sroot_in[j] = {root[ROOT_W-2:0], 1'b1};
         end else begin
            srem_in[j]  = rem;
            sroot_in[j] = {root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Restoring division of (mag * 2^22 + len / 2) by len, four lanes.
   always_comb begin
      logic [ROOT_W-1:0] len;
      logic [NUM_W:0]    dvs;
      logic [NUM_W:0]    remx;
      len = sroot_ff[ROOT_W-1];
      for (int i = 0; i < 4; i++) begin
         drem_in[0][i] = {1'b0, smag_ff[ROOT_W-1][i], 22'd0} + NUM_W'(len >> 1);
         dq_in[0][i]   = '0;
      end
      for (int s = 1; s < DN; s++) begin
         for (int i = 0; i < 4; i++) begin
            dvs  = {{(NUM_W+1-ROOT_W){1'b0}}, dlen_ff[s-1]} << (Q_W - s);
            remx = {1'b0, drem_ff[s-1][i]};
            if (remx >= dvs) begin
               drem_in[s][i] = NUM_W'(remx - dvs);
               dq_in[s][i]   = dq_ff[s-1][i] | (Q_W'(1) << (Q_W - s));
            end else begin
               drem_in[s][i] = drem_ff[s-1][i];
               dq_in[s][i]   = dq_ff[s-1][i];
            end
         end
      end
   end

   always_comb begin
      logic [Q_W-1:0]   q;
      logic [FIELD_W-1:0] pos;
      logic             nrm;
      logic             zero;
      nrm  = (dmode_ff[DN-1] == MODE_NORMALIZE);
      zero = (dsum_ff[DN-1] == '0);
      rzero_in = nrm && zero;
      for (int i = 0; i < 4; i++) begin
         q   = (dq_ff[DN-1][i] > NORM_ONE) ? NORM_ONE : dq_ff[DN-1][i];
         pos = {1'b0, q};
         if (!nrm || zero) begin
            rnorm_in[i] = '0;
         end else begin
            rnorm_in[i] = dneg_ff[DN-1][i] ? FIELD_W'(-pos) : pos;
         end
      end
      unique case (dmode_ff[DN-1])
         MODE_SUM_SQ: begin
            rscalar_in = (dsum_ff[DN-1] > SUM_W'(SCALAR_MAX)) ? SCALAR_MAX
                                                              : SCALAR_W'(dsum_ff[DN-1]);
         end
         MODE_LENGTH: rscalar_in = SCALAR_W'(dlen_ff[DN-1] >> 8);
         default:     rscalar_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rv_ff <= 1'b0;
         for (int j = 0; j < ROOT_W; j++) sv_ff[j] <= 1'b0;
         for (int s = 0; s < DN; s++) dv_ff[s] <= 1'b0;
      end else if (en) begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         sv_ff[0] <= v2_ff;
         for (int j = 1; j < ROOT_W; j++) sv_ff[j] <= sv_ff[j-1];
         dv_ff[0] <= sv_ff[ROOT_W-1];
         for (int s = 1; s < DN; s++) dv_ff[s] <= dv_ff[s-1];
         rv_ff <= dv_ff[DN-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= mode1_in;
         neg1_ff  <= neg1_in;
         mag1_ff  <= mag1_in;
         sq1_ff   <= sq1_in;

         mode2_ff <= mode1_ff;
         neg2_ff  <= neg1_ff;
         mag2_ff  <= mag1_ff;
         sum2_ff  <= sum2_in;

         for (int j = 0; j < ROOT_W; j++) begin
            if (j == 0) begin
               smode_ff[j] <= mode2_ff;
               sneg_ff[j]  <= neg2_ff;
               smag_ff[j]  <= mag2_ff;
               ssum_ff[j]  <= sum2_ff;
            end else begin
               smode_ff[j] <= smode_ff[j-1];
               sneg_ff[j]  <= sneg_ff[j-1];
               smag_ff[j]  <= smag_ff[j-1];
               ssum_ff[j]  <= ssum_ff[j-1];
            end
            srem_ff[j]  <= srem_in[j];
            sroot_ff[j] <= sroot_in[j];
         end

         for (int s = 0; s < DN; s++) begin
            if (s == 0) begin
               dmode_ff[s] <= smode_ff[ROOT_W-1];
               dneg_ff[s]  <= sneg_ff[ROOT_W-1];
               dsum_ff[s]  <= ssum_ff[ROOT_W-1];
               dlen_ff[s]  <= sroot_ff[ROOT_W-1];
            end else begin
               dmode_ff[s] <= dmode_ff[s-1];
               dneg_ff[s]  <= dneg_ff[s-1];
               dsum_ff[s]  <= dsum_ff[s-1];
               dlen_ff[s]  <= dlen_ff[s-1];
            end
            drem_ff[s] <= drem_in[s];
            dq_ff[s]   <= dq_in[s];
         end

         rnorm_ff   <= rnorm_in;
         rscalar_ff <= rscalar_in;
         rzero_ff   <= rzero_in;
      end
   end

   assign rsp_valid         = rv_ff;
   assign rsp_norm_x        = rnorm_ff[0];
   assign rsp_norm_y        = rnorm_ff[1];
   assign rsp_norm_z        = rnorm_ff[2];
   assign rsp_norm_w        = rnorm_ff[3];
   assign rsp_scalar_result = rscalar_ff;
   assign rsp_zero_length   = rzero_ff;
endmodule
`default_nettype wire

// ===== design/vnl_checker.sv =====
`default_nettype none
module vnl_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_x,
   input wire logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_y,
   input wire logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_z,
   input wire logic [vnl_pkg::FIELD_W-1:0]   rsp_norm_w,
   input wire logic [vnl_pkg::SCALAR_W-1:0]  rsp_scalar_result,
   input wire logic                          rsp_zero_length
);
   import vnl_pkg::*;

   // A taken or absent response always frees the pipeline for a new request.
   a_ready_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("request not accepted while pipeline can advance");

   // A zero-length vector yields zero components and no scalar.
   a_zero_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_length) |-> (rsp_norm_x == '0 && rsp_norm_y == '0 &&
         rsp_norm_z == '0 && rsp_norm_w == '0 && rsp_scalar_result == '0))
      else $error("zero-length response carries data");

   // Normalized components and the scalar never appear together.
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_norm_x != '0 || rsp_norm_y != '0 || rsp_norm_z != '0 ||
         rsp_norm_w != '0)) |-> (rsp_scalar_result == '0 && !rsp_zero_length))
      else $error("normalized response mixed with scalar");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_scalar_result) &&
         $stable(rsp_norm_x)))
      else $error("stalled response changed");
endmodule

bind vector_normalize_length_unit vnl_checker u_vnl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_norm_x        (rsp_norm_x),
   .rsp_norm_y        (rsp_norm_y),
   .rsp_norm_z        (rsp_norm_z),
   .rsp_norm_w        (rsp_norm_w),
   .rsp_scalar_result (rsp_scalar_result),
   .rsp_zero_length   (rsp_zero_length)
);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
   import vnl_pkg::*;

   typedef struct packed {
      logic [15:0] nx, ny, nz, nw;
      logic [32:0] scalar;
      logic        zero_len;
   } vec_result_t;

   class vec_scoreboard;
      vec_result_t pending[$];
      int          errors;

      // Integer square root, bit by bit, floor result.
      function automatic longint unsigned isqrt(longint unsigned v);
         longint unsigned root, b;
         root = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= root + b) begin
               v = v - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      endfunction

      function void note_request(logic [1:0] mode, logic [2:0] dims,
                                 logic [15:0] cx, logic [15:0] cy,
                                 logic [15:0] cz, logic [15:0] cw);
         logic [15:0]     raw[4];
         longint          comp[4];
         longint unsigned mag[4];
         longint unsigned sum, len, q;
         int              n;
         vec_result_t     r;
         raw[0] = cx; raw[1] = cy; raw[2] = cz; raw[3] = cw;
         n = (dims < 2) ? 2 : (dims > 4) ? 4 : dims;
         sum = 0;
         for (int i = 0; i < 4; i++) begin
            comp[i] = (i < n) ? longint'($signed(raw[i])) : 0;
            mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
            sum += mag[i] * mag[i];
         end
         r = '0;
         if (mode == MODE_NORMALIZE) begin
            if (sum == 0) begin
               r.zero_len = 1'b1;
            end else begin
               len = isqrt(sum << 16);
               for (int i = 0; i < 4; i++) begin
                  q = ((mag[i] << 22) + (len >> 1)) / len;
                  if (q > 16384) q = 16384;
                  if (comp[i] < 0) q = -q;
                  case (i)
                     0: r.nx = q[15:0];
                     1: r.ny = q[15:0];
                     2: r.nz = q[15:0];
                     default: r.nw = q[15:0];
                  endcase
               end
            end
         end else if (mode == MODE_SUM_SQ) begin
            r.scalar = (sum > 64'h1FFFFFFFF) ? SCALAR_MAX : sum[32:0];
         end else if (mode == MODE_LENGTH) begin
            len = isqrt(sum);
            r.scalar = len[32:0];
         end
         pending.push_back(r);
      endfunction

      function void check_response(vec_result_t got);
         vec_result_t exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.nx !== exp.nx) begin
            $display("%0t: norm_x expected %h actual %h", $time, exp.nx, got.nx);
            errors++;
         end
         if (got.ny !== exp.ny) begin
            $display("%0t: norm_y expected %h actual %h", $time, exp.ny, got.ny);
            errors++;
         end
         if (got.nz !== exp.nz) begin
            $display("%0t: norm_z expected %h actual %h", $time, exp.nz, got.nz);
            errors++;
         end
         if (got.nw !== exp.nw) begin
            $display("%0t: norm_w expected %h actual %h", $time, exp.nw, got.nw);
            errors++;
         end
         if (got.scalar !== exp.scalar) begin
            $display("%0t: scalar_result expected %h actual %h", $time,
                     exp.scalar, got.scalar);
            errors++;
         end
         if (got.zero_len !== exp.zero_len) begin
            $display("%0t: zero_length expected %b actual %b", $time,
                     exp.zero_len, got.zero_len);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_mode = '0;
   logic [2:0]  req_dims = '0;
   logic [15:0] req_comp_x = '0, req_comp_y = '0, req_comp_z = '0, req_comp_w = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_norm_w;
   logic [32:0] rsp_scalar_result;
   logic        rsp_zero_length;

   vec_scoreboard board = new();
   int unsigned   cycle_count = 0;
   bit            hold_off = 0;

   vector_normalize_length_unit uut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("tb failed");
         $finish;
      end
   end

   // Requests and responses are recorded at the edge where they are taken.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         board.note_request(req_mode, req_dims, req_comp_x, req_comp_y,
                            req_comp_z, req_comp_w);
      if (!reset && rsp_valid && rsp_ready)
         board.check_response({rsp_norm_x, rsp_norm_y, rsp_norm_z, rsp_norm_w,
                               rsp_scalar_result, rsp_zero_length});
   end

   // Receiver: stalls in its own pattern, with one long hold-off on request.
   initial begin
      int run;
      @(posedge clock);
      while (1) begin
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         run = $urandom_range(1, 20);
         case ($urandom_range(0, 2))
            0: begin
               rsp_ready <= 1'b1;
               repeat (run) @(posedge clock);
            end
            1: begin
               rsp_ready <= 1'b0;
               repeat (run) @(posedge clock);
            end
            default: begin
               repeat (run) begin
                  rsp_ready <= 1'($urandom_range(0, 1));
                  @(posedge clock);
               end
            end
         endcase
      end
   end

   int burst_left = 0;

   task automatic send_request(logic [1:0] mode, logic [2:0] dims,
                               logic [15:0] cx, logic [15:0] cy,
                               logic [15:0] cz, logic [15:0] cw);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         // Valid only drops when a nonzero gap follows.
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_mode <= mode;
      req_dims <= dims;
      req_comp_x <= cx;
      req_comp_y <= cy;
      req_comp_z <= cz;
      req_comp_w <= cw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic [15:0] random_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($signed($urandom_range(0, 64)) - 32);
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] e[6];
      e = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h0100};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Extremes, every mode and dims, zero vectors, unused mode and dims.
      send_request(MODE_NORMALIZE, 3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(MODE_NORMALIZE, 3'd2, 16'h0000, 16'h0000, 16'h1234, 16'h5678);
      send_request(MODE_NORMALIZE, 3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(MODE_NORMALIZE, 3'd2, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
      send_request(MODE_NORMALIZE, 3'd3, 16'h0001, 16'hFFFF, 16'h0001, 16'h0000);
      send_request(MODE_NORMALIZE, 3'd2, 16'h8000, 16'h0000, 16'h7FFF, 16'h7FFF);
      send_request(MODE_SUM_SQ, 3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(MODE_SUM_SQ, 3'd4, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_request(MODE_SUM_SQ, 3'd3, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_request(MODE_LENGTH, 3'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_request(MODE_LENGTH, 3'd2, 16'h0300, 16'h0400, 16'h0000, 16'h0000);
      send_request(MODE_LENGTH, 3'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_request(2'd3, 3'd4, 16'h1111, 16'h2222, 16'h3333, 16'h4444);
      send_request(MODE_NORMALIZE, 3'd0, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
      send_request(MODE_SUM_SQ, 3'd1, 16'h0100, 16'h0100, 16'h0100, 16'h0100);
      send_request(MODE_LENGTH, 3'd7, 16'h0100, 16'h0100, 16'h0100, 16'hFFFF);
      send_request(MODE_SUM_SQ, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_request(MODE_NORMALIZE, 3'd6, 16'h0001, 16'h0000, 16'h0000, 16'h0000);

      for (int i = 0; i < 600; i++) begin
         // Partway through, the receiver backs off so the pipeline fills up.
         if (i == 200) hold_off = 1;
         if ($urandom_range(0, 9) == 0)
            send_request(2'($urandom), 3'($urandom), e[$urandom_range(0, 5)],
                         random_comp(), 16'($urandom), e[$urandom_range(0, 5)]);
         else
            send_request(2'($urandom_range(0, 2)), 3'($urandom_range(2, 4)),
                         random_comp(), random_comp(), random_comp(), random_comp());
      end
      req_valid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (board.errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
